[design/rlrx_pkg.sv]
// Shared types and constants for the reliable link receive classifier.
`default_nettype none
package rlrx_pkg;

    localparam int LEN_W = 12;
    localparam int SEQ_W = 16;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 12'd596;

    localparam logic [2:0] TYPE_DATA  = 3'd0;
    localparam logic [2:0] TYPE_ACK   = 3'd1;
    localparam logic [2:0] TYPE_LAST  = 3'd2;
    localparam logic [2:0] TYPE_CTL   = 3'd3;
    localparam logic [2:0] TYPE_IC    = 3'd4;
    localparam logic [2:0] TYPE_CI    = 3'd5;

    localparam logic [1:0] HS_NONE = 2'd0;
    localparam logic [1:0] HS_IC   = 2'd1;
    localparam logic [1:0] HS_CI   = 2'd2;

    typedef enum logic [3:0] {
        ACT_GOODACK        = 4'd0,
        ACT_DUPACK         = 4'd1,
        ACT_STATS          = 4'd2,
        ACT_CTLOTHER       = 4'd3,
        ACT_LINKRESET      = 4'd4,
        ACT_CIIGNORED      = 4'd5,
        ACT_ACCEPT         = 4'd6,
        ACT_REACK          = 4'd7,
        ACT_DROP           = 4'd8,
        ACT_BAD            = 4'd9,
        ACT_CONNECT        = 4'd10,
        ACT_ICREPLY        = 4'd11,
        ACT_UNCONNIGNORED  = 4'd12,
        ACT_TXRECORDED     = 4'd13,
        ACT_TXFULL         = 4'd14,
        ACT_TXNOTCONNECTED = 4'd15
    } action_t;

    // Class of a received header while connected, in priority order.
    typedef enum logic [2:0] {
        KIND_ACK,
        KIND_CTL,
        KIND_LRESET,
        KIND_CIIGN,
        KIND_DATA,
        KIND_BAD
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TX,
        ST_ACK
    } back_state_t;

    typedef struct packed {
        logic             is_tx;
        kind_t            kind;
        logic             is_ic;
        logic             is_ci;
        logic             last_frag;
        logic             ctl_stats;
        logic             rdq_full;
        logic             ackq_full;
        logic [SEQ_W-1:0] seq;
    } cmd_t;

    typedef struct packed {
        action_t          action;
        logic [SEQ_W-1:0] ack_seqn;
        logic [1:0]       hs;
        logic [SEQ_W-1:0] tx_seqn;
        logic             fin;
        logic             conn;
    } res_t;

endpackage
`default_nettype wire

[design/rlrx_ram.sv]
// Generic single-port-write RAM with registered read.
`default_nettype none
module rlrx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[design/rlrx_front.sv]
// Front end: takes headers, holds the payload limit, classifies into commands.
`default_nettype none
module rlrx_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [rlrx_pkg::LEN_W-1:0] cfg_wr_data,
    input  wire logic                      func,
    input  wire logic [31:0]               packet_header,
    input  wire logic [7:0]                first_payload_byte,
    input  wire logic                      read_queue_full,
    input  wire logic                      ack_queue_full,
    output rlrx_pkg::cmd_t                 cmd
);
    import rlrx_pkg::*;

    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] len;
    logic [2:0]       ptype;
    logic             len_zero;
    logic             len_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    assign len      = packet_header[LEN_W-1:0];
    assign ptype    = packet_header[14:12];
    assign len_zero = (len == '0);
    assign len_ok   = (len <= max_len_reg);

    always_comb
    begin
        cmd           = '0;
        cmd.is_tx     = func;
        cmd.is_ic     = (ptype == TYPE_IC);
        cmd.is_ci     = (ptype == TYPE_CI);
        cmd.last_frag = (ptype == TYPE_LAST);
        cmd.ctl_stats = (first_payload_byte == 8'd0);
        cmd.rdq_full  = read_queue_full;
        cmd.ackq_full = ack_queue_full;
        cmd.seq       = packet_header[31:16];
        if (ptype == TYPE_ACK && len_zero)
        begin
            cmd.kind = KIND_ACK;
        end
        else if (ptype == TYPE_CTL && len_ok)
        begin
            cmd.kind = KIND_CTL;
        end
        else if (ptype == TYPE_IC && len_zero)
        begin
            cmd.kind = KIND_LRESET;
        end
        else if (ptype == TYPE_CI && len_zero)
        begin
            cmd.kind = KIND_CIIGN;
        end
        else if ((ptype == TYPE_DATA || ptype == TYPE_LAST) && !len_zero && len_ok)
        begin
            cmd.kind = KIND_DATA;
        end
        else
        begin
            cmd.kind = KIND_BAD;
        end
    end
endmodule
`default_nettype wire

[design/rlrx_cmd_fifo.sv]
// Two-entry command queue between front and back.
`default_nettype none
module rlrx_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rlrx_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output rlrx_pkg::cmd_t      head,
    output logic                full,
    output logic                empty
);
    import rlrx_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

[design/rlrx_back.sv]
// Back end: link state, outstanding table scans and the result register.
`default_nettype none
module rlrx_back #(
    parameter int ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire rlrx_pkg::cmd_t q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rlrx_pkg::res_t      res
);
    import rlrx_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] SCAN_LAST = CW'(ENTRIES - 1);
    localparam logic [AW-1:0] IDX_LAST  = AW'(ENTRIES - 1);

    back_state_t        state_reg, state_next;
    cmd_t               cur_reg, cur_next;
    logic               conn_reg, conn_next;
    logic [SEQ_W-1:0]   exp_reg, exp_next;
    logic [SEQ_W-1:0]   ntx_reg, ntx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_next;

    logic             out_free;
    logic             load;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [SEQ_W-1:0] ram_rdata;

    rlrx_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_seq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ntx_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        logic [AW-1:0]    idx;
        logic [SEQ_W-1:0] diff;
        logic             hit;
        logic             last;
        res_t             r;

        state_next     = state_reg;
        cur_next       = cur_reg;
        conn_next      = conn_reg;
        exp_next       = exp_reg;
        ntx_next       = ntx_reg;
        valid_next     = valid_reg;
        scan_next      = scan_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        q_pop          = 1'b0;
        load           = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = scan_reg[AW-1:0];
        ram_raddr      = scan_reg[AW-1:0];
        idx            = scan_reg[AW-1:0];
        diff           = cur_reg.seq - exp_reg;
        hit            = cmp_valid_reg && valid_reg[cmp_idx_reg] && (ram_rdata == cur_reg.seq);
        last           = cmp_valid_reg && (cmp_idx_reg == IDX_LAST);

        r          = '0;
        r.action   = ACT_BAD;
        r.hs       = HS_NONE;
        r.conn     = conn_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    cur_next       = q_head;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (cur_reg.is_tx && conn_reg)
                begin
                    state_next = ST_TX;
                end
                else if (!cur_reg.is_tx && conn_reg && cur_reg.kind == KIND_ACK)
                begin
                    state_next = ST_ACK;
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    if (cur_reg.is_tx)
                    begin
                        r.action = ACT_TXNOTCONNECTED;
                    end
                    else if (!conn_reg)
                    begin
                        if (cur_reg.is_ci)
                        begin
                            exp_next   = '0;
                            ntx_next   = '0;
                            valid_next = '0;
                            conn_next  = 1'b1;
                            r.conn     = 1'b1;
                            r.hs       = HS_CI;
                            r.action   = ACT_CONNECT;
                        end
                        else if (cur_reg.is_ic)
                        begin
                            r.hs     = HS_CI;
                            r.action = ACT_ICREPLY;
                        end
                        else
                        begin
                            r.action = ACT_UNCONNIGNORED;
                        end
                    end
                    else
                    begin
                        case (cur_reg.kind)
                            KIND_CTL:
                            begin
                                r.action = cur_reg.ctl_stats ? ACT_STATS : ACT_CTLOTHER;
                            end
                            KIND_LRESET:
                            begin
                                exp_next   = '0;
                                ntx_next   = '0;
                                valid_next = '0;
                                conn_next  = 1'b0;
                                r.conn     = 1'b0;
                                r.hs       = HS_IC;
                                r.action   = ACT_LINKRESET;
                            end
                            KIND_CIIGN:
                            begin
                                r.action = ACT_CIIGNORED;
                            end
                            KIND_DATA:
                            begin
                                // behind: signed distance to the expected sequence is negative
                                if (diff[SEQ_W-1] && !cur_reg.ackq_full)
                                begin
                                    r.ack_seqn = cur_reg.seq;
                                    r.action   = ACT_REACK;
                                end
                                else if (diff == '0 && !cur_reg.rdq_full
                                         && !cur_reg.ackq_full)
                                begin
                                    r.ack_seqn = cur_reg.seq;
                                    r.fin      = cur_reg.last_frag;
                                    exp_next   = cur_reg.seq + SEQ_W'(1);
                                    r.action   = ACT_ACCEPT;
                                end
                                else
                                begin
                                    r.action = ACT_DROP;
                                end
                            end
                            default:
                            begin
                                r.action = ACT_BAD;
                            end
                        endcase
                    end
                end
            end

            ST_TX:
            begin
                // walk the valid bits for the lowest free entry
                if (!valid_reg[idx])
                begin
                    if (out_free)
                    begin
                        ram_we          = 1'b1;
                        valid_next[idx] = 1'b1;
                        ntx_next        = ntx_reg + SEQ_W'(1);
                        r.tx_seqn       = ntx_reg;
                        r.action        = ACT_TXRECORDED;
                        load            = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (scan_reg == SCAN_LAST)
                begin
                    if (out_free)
                    begin
                        r.action   = ACT_TXFULL;
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end

            ST_ACK:
            begin
                // read one entry a cycle, compare it the cycle after
                if (hit)
                begin
                    if (out_free)
                    begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        r.action   = ACT_GOODACK;
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (last)
                begin
                    if (out_free)
                    begin
                        r.action   = ACT_DUPACK;
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ram_re         = 1'b1;
                    cmp_idx_next   = idx;
                    cmp_valid_next = 1'b1;
                    scan_next      = scan_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next       = load ? r : res_reg;
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            conn_reg      <= 1'b0;
            exp_reg       <= '0;
            ntx_reg       <= '0;
            valid_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conn_reg      <= conn_next;
            exp_reg       <= exp_next;
            ntx_reg       <= ntx_next;
            valid_reg     <= valid_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

[design/reliable_link_rx_classifier.sv]
// Top level of the reliable link receive classifier.
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  ---------------------------------------------
//  in       input      in_valid/in_ready  func, packet_header, first_payload_byte,
//                                         read_queue_full, ack_queue_full
//  out      output     out_valid/out_ready action, ack_seqn, handshake_send,
//                                         assigned_tx_seqn, final_fragment, link_connected
//  cfg      input      cfg_wr_en          cfg_wr_data (max_payload_bytes)
//
// The front decodes one header a cycle into a two-entry command queue while it has room.
// The back takes an item that needs no table access straight to its result; a sent-data
// item walks the outstanding table for its first free entry, and an ack while connected
// walks it for the entry that matches its sequence; both walk one entry a cycle, the ack
// walk through the table's RAM read port.
// Reset leaves the link unconnected with an empty table; no clearing pass is needed.
// A stalled output holds the back end; the front keeps filling the queue meanwhile.
`default_nettype none
module reliable_link_rx_classifier #(
    parameter int OUTSTANDING_ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [11:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [31:0] packet_header,
    input  wire logic [7:0]  first_payload_byte,
    input  wire logic        read_queue_full,
    input  wire logic        ack_queue_full,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       action,
    output logic [15:0]      ack_seqn,
    output logic [1:0]       handshake_send,
    output logic [15:0]      assigned_tx_seqn,
    output logic             final_fragment,
    output logic             link_connected
);
    import rlrx_pkg::*;

    cmd_t front_cmd;
    cmd_t q_head;
    res_t res;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic q_push;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    rlrx_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .func               (func),
        .packet_header      (packet_header),
        .first_payload_byte (first_payload_byte),
        .read_queue_full    (read_queue_full),
        .ack_queue_full     (ack_queue_full),
        .cmd                (front_cmd)
    );

    rlrx_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    rlrx_back #(
        .ENTRIES (OUTSTANDING_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign action           = res.action;
    assign ack_seqn         = res.ack_seqn;
    assign handshake_send   = res.hs;
    assign assigned_tx_seqn = res.tx_seqn;
    assign final_fragment   = res.fin;
    assign link_connected   = res.conn;
endmodule
`default_nettype wire
